// ----- hdl/fspa_pkg.sv -----
// Shared types and constants for the fixed-size pool allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package fspa_pkg;

  // Field widths of requests, results and configuration registers
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OFFS_W   = 22;
  localparam int unsigned STRIDE_W = 13;
  localparam int unsigned BLOCK_W  = 11;

  // APB register window: two 32-bit registers at byte addresses 0 and 4
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd16;
  localparam logic [BLOCK_W-1:0]  BLOCK_RST  = 11'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_OOM      = 2'd1,
    STS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    REG_STRIDE = 1'b0,
    REG_BLOCK  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } fsm_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;   // capture the request and start the link read
    logic commit;  // update the pool state and load the result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } dp_sts_t;

endpackage

// ----- hdl/fspa_ifs.sv -----
// Valid/ready channel interfaces for allocator requests and results.
// Depends on fspa_pkg for the field widths.
interface fspa_req_if
  import fspa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, cmd, slot_index, input ready);
  modport sink   (input valid, cmd, slot_index, output ready);
endinterface

interface fspa_rsp_if
  import fspa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_index;
  logic [OFFS_W-1:0]   byte_offset;
  logic                from_free_list;

  modport source (output valid, status, granted_index, byte_offset, from_free_list,
                  input ready);
  modport sink   (input valid, status, granted_index, byte_offset, from_free_list,
                  output ready);
endinterface

// ----- hdl/fspa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fspa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fspa_ctrl.sv -----
// Request sequencer: takes a request, then commits it once the result register is free.
// Depends on fspa_pkg for the state, command and status types.
module fspa_ctrl
  import fspa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  fsm_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    req_ready_o  = 1'b0;
    cmd_o.latch  = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Wait for room in the result register
        if (!sts_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/fspa_dp.sv -----
// Allocator datapath: pool state, free-list link memory, result register.
// Depends on fspa_pkg and fspa_ram.
module fspa_dp
  import fspa_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            cmd_i,
  output dp_sts_t             sts_o,
  input  logic [CMD_W-1:0]    req_cmd_i,
  input  logic [SLOT_W-1:0]   req_slot_i,
  input  logic [STRIDE_W-1:0] stride_i,
  input  logic [BLOCK_W-1:0]  block_elems_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [SLOT_W-1:0]   rsp_index_o,
  output logic [OFFS_W-1:0]   rsp_offset_o,
  output logic                rsp_ffl_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((NW > SLOT_W) ? NW : SLOT_W);
  localparam int unsigned SW = ((NW > BLOCK_W) ? NW : BLOCK_W) + 1;
  localparam int unsigned PW = IW + STRIDE_W;

  // Captured request
  logic [CMD_W-1:0]  cmd_q;
  logic [SLOT_W-1:0] slot_q;

  // Pool state
  logic [IW-1:0] free_head_q, free_head_d;
  logic          free_empty_q, free_empty_d;
  logic [NW-1:0] next_unused_q, next_unused_d;
  logic [NW-1:0] block_end_q, block_end_d;

  // Result register
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0]   index_q, index_d;
  logic [OFFS_W-1:0]   offset_q, offset_d;
  logic                ffl_q, ffl_d;

  // Link memory signals
  logic          link_we;
  logic [IW-1:0] link_waddr, link_wdata, link_rdata;

  logic [IW-1:0]      res_idx;
  logic               grant;
  logic [PW-1:0]      prod;
  logic [BLOCK_W-1:0] blk_n;
  logic [SW-1:0]      blk_sum;
  logic               oom, need_block, free_bad;

  fspa_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i.latch),
    .raddr_i (free_head_q),
    .rdata_o (link_rdata)
  );

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= req_cmd_i;
      slot_q <= req_slot_i;
    end
  end

  // Decisions on the current pool state
  assign blk_n      = (block_elems_i == '0) ? BLOCK_W'(1) : block_elems_i;
  assign blk_sum    = SW'(next_unused_q) + SW'(blk_n);
  assign oom        = blk_sum > SW'(CAPACITY);
  assign need_block = next_unused_q >= block_end_q;
  assign free_bad   = (CW'(slot_q) >= CW'(next_unused_q)) || (CW'(slot_q) >= CW'(CAPACITY));

  // Next pool state, link write and result fields
  always_comb begin
    free_head_d   = free_head_q;
    free_empty_d  = free_empty_q;
    next_unused_d = next_unused_q;
    block_end_d   = block_end_q;
    link_we       = 1'b0;
    link_waddr    = IW'(slot_q);
    link_wdata    = free_empty_q ? IW'(slot_q) : free_head_q;
    status_d      = STS_OK;
    res_idx       = '0;
    grant         = 1'b0;
    ffl_d         = 1'b0;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (!free_empty_q) begin
          // Pop the free list; a self-link marks the tail
          res_idx = free_head_q;
          grant   = 1'b1;
          ffl_d   = 1'b1;
          if (link_rdata == free_head_q) begin
            free_empty_d = 1'b1;
          end else begin
            free_head_d = link_rdata;
          end
        end else if (need_block && oom) begin
          status_d = STS_OOM;
        end else begin
          // Bump allocate, opening a block when needed
          res_idx       = IW'(next_unused_q);
          grant         = 1'b1;
          next_unused_d = next_unused_q + NW'(1);
          if (need_block) begin
            block_end_d = NW'(blk_sum);
          end
        end
      end
      CMD_FREE: begin
        if (free_bad) begin
          status_d = STS_BAD_FREE;
        end else begin
          link_we      = cmd_i.commit;
          free_head_d  = IW'(slot_q);
          free_empty_d = 1'b0;
        end
      end
      CMD_RELEASE: begin
        free_head_d   = '0;
        free_empty_d  = 1'b1;
        next_unused_d = '0;
        block_end_d   = '0;
      end
      default: begin
      end
    endcase
    prod     = PW'(res_idx) * PW'(stride_i);
    index_d  = grant ? SLOT_W'(res_idx) : '0;
    offset_d = grant ? OFFS_W'(prod) : '0;
  end

  // Pool state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q   <= '0;
      free_empty_q  <= 1'b1;
      next_unused_q <= '0;
      block_end_q   <= '0;
    end else if (cmd_i.commit) begin
      free_head_q   <= free_head_d;
      free_empty_q  <= free_empty_d;
      next_unused_q <= next_unused_d;
      block_end_q   <= block_end_d;
    end
  end

  // Result valid: set on commit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      index_q  <= index_d;
      offset_q <= offset_d;
      ffl_q    <= ffl_d;
    end
  end

  assign sts_o.out_stall = rsp_valid_q && !rsp_ready_i;
  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_status_o    = status_q;
  assign rsp_index_o     = index_q;
  assign rsp_offset_o    = offset_q;
  assign rsp_ffl_o       = ffl_q;

  // A commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(rsp_valid_q && !rsp_ready_i))
    else $error("result overwritten while stalled");

  // Bump pointer never passes the end of the open block
  a_bump_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_unused_q <= block_end_q)
    else $error("next unused slot beyond block end");

  // Open block always lies inside the pool
  a_block_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(block_end_q) <= CW'(CAPACITY))
    else $error("block end beyond capacity");

  // Free-list head is always a slot already handed out
  a_head_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !free_empty_q |-> (CW'(free_head_q) < CW'(next_unused_q)))
    else $error("free-list head never issued");

endmodule

// ----- hdl/fixed_size_pool_allocator_top.sv -----
// Fixed-size pool allocator: top level with APB configuration registers.
// A request is accepted in the idle state and its result is loaded on commit from the exec state,
// which waits while the result register is full. A new request is taken only after the last one
// commits, because of the registered read of the free-list link memory ahead of the head update.
// Reset: pool empty, no block open, stride 16, block size 64; link memory needs no clearing.
// Depends on fspa_pkg, fspa_ifs, fspa_ctrl, fspa_dp and fspa_ram.
module fixed_size_pool_allocator_top
  import fspa_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fspa_req_if.sink          req_i,
  fspa_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [STRIDE_W-1:0] stride_q;
  logic [BLOCK_W-1:0]  block_q;
  logic                cfg_we;
  cfg_reg_e            cfg_sel;
  ctl_cmd_t            ctl_cmd;
  dp_sts_t             dp_sts;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RST;
      block_q  <= BLOCK_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_STRIDE: stride_q <= pwdata[STRIDE_W-1:0];
        REG_BLOCK:  block_q  <= pwdata[BLOCK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_sel)
      REG_STRIDE: prdata = APB_DW'(stride_q);
      REG_BLOCK:  prdata = APB_DW'(block_q);
      default:    prdata = '0;
    endcase
  end

  fspa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd)
  );

  fspa_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .sts_o         (dp_sts),
    .req_cmd_i     (req_i.cmd),
    .req_slot_i    (req_i.slot_index),
    .stride_i      (stride_q),
    .block_elems_i (block_q),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_status_o  (rsp_o.status),
    .rsp_index_o   (rsp_o.granted_index),
    .rsp_offset_o  (rsp_o.byte_offset),
    .rsp_ffl_o     (rsp_o.from_free_list)
  );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for fixed_size_pool_allocator_top: directed and random requests,
// APB register writes between phases, results checked against an in-bench pool tracker.
// Depends on fspa_pkg, fspa_ifs and the allocator RTL.
module tb;
  import fspa_pkg::*;

  localparam int unsigned POOL_SLOTS  = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYC  = 4;

  // Command code outside the defined set; the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   idx;
    logic [OFFS_W-1:0]   offs;
    logic                ffl;
  } grant_t;

  // Tracks the pool state and the results each accepted request must produce
  class grant_tracker;
    logic [SLOT_W-1:0]   link_mem [POOL_SLOTS];
    logic [SLOT_W-1:0]   head;
    logic                empty;
    logic [BLOCK_W-1:0]  next_slot;
    logic [BLOCK_W-1:0]  blk_end;
    logic [STRIDE_W-1:0] stride;
    logic [BLOCK_W-1:0]  blk_size;
    grant_t              pending_grants [$];
    int                  mismatches;

    function new();
      head       = '0;
      empty      = 1'b1;
      next_slot  = '0;
      blk_end    = '0;
      stride     = STRIDE_RST;
      blk_size   = BLOCK_RST;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // Advance the pool by one accepted request and queue its result
    function void note_request(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s);
      grant_t              g;
      logic [SLOT_W-1:0]   nxt;
      int unsigned         span;
      logic [OFFS_W:0]     prod;
      g = '0;
      case (c)
        CMD_ALLOC: begin
          if (!empty) begin
            nxt   = link_mem[head];
            g.idx = head;
            g.ffl = 1'b1;
            // a self-link marks the tail of the list
            if (nxt == head) empty = 1'b1;
            else head = nxt;
          end else begin
            span = (blk_size == 0) ? 1 : int'(blk_size);
            if (next_slot >= blk_end && int'(next_slot) + span > POOL_SLOTS) begin
              g.status = STS_OOM;
            end else begin
              if (next_slot >= blk_end) blk_end = next_slot + BLOCK_W'(span);
              g.idx     = next_slot[SLOT_W-1:0];
              next_slot = next_slot + 1'b1;
            end
          end
        end
        CMD_FREE: begin
          if ({1'b0, s} >= next_slot) begin
            g.status = STS_BAD_FREE;
          end else begin
            link_mem[s] = empty ? s : head;
            head        = s;
            empty       = 1'b0;
          end
        end
        CMD_RELEASE: begin
          head      = '0;
          empty     = 1'b1;
          next_slot = '0;
          blk_end   = '0;
        end
        default: begin
        end
      endcase
      prod   = g.idx * stride;
      g.offs = prod[OFFS_W-1:0];
      pending_grants.push_back(g);
    endfunction

    // Compare one delivered result with the oldest queued one
    function void check_grant(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d idx=%0d offs=%0d ffl=%0d",
                   got.status, got.idx, got.offs, got.ffl);
        return;
      end
      want = pending_grants.pop_front();
      if (got.status !== want.status || got.idx !== want.idx ||
          got.offs !== want.offs || got.ffl !== want.ffl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("exp st=%0d idx=%0d offs=%0d ffl=%0d, got st=%0d idx=%0d offs=%0d ffl=%0d",
                   want.status, want.idx, want.offs, want.ffl,
                   got.status, got.idx, got.offs, got.ffl);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fspa_req_if req_if ();
  fspa_rsp_if rsp_if ();

  grant_tracker tracker = new();
  int unsigned  cycles;
  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;

  fixed_size_pool_allocator_top #(
    .CAPACITY (POOL_SLOTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hold off the result channel in random bursts
  initial begin : rsp_ready_gen
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Check every delivered result
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      tracker.check_grant({rsp_if.status, rsp_if.granted_index, rsp_if.byte_offset,
                           rsp_if.from_free_list});
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= c;
    req_if.slot_index <= s;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(c, s);
  endtask

  // Stop sending and wait until every queued result has arrived
  task automatic drain();
    req_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Setup and access cycle, then the bus returns to idle
  task automatic write_reg(input cfg_reg_e r, input logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers while the pool is quiet; upper bus bits carry noise
  task automatic configure(input logic [STRIDE_W-1:0] st, input logic [BLOCK_W-1:0] bs);
    logic [APB_DW-1:0] v;
    drain();
    v = $urandom;
    v[STRIDE_W-1:0] = st;
    write_reg(REG_STRIDE, v);
    tracker.stride = st;
    v = $urandom;
    v[BLOCK_W-1:0] = bs;
    write_reg(REG_BLOCK, v);
    tracker.blk_size = bs;
  endtask

  // Random mix: allocations, frees of issued slots, releases, then noise
  task automatic run_phase(input int n, input int alloc_pct, input int free_pct,
                           input int rel_pct);
    int                r;
    logic [SLOT_W-1:0] s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = SLOT_W'($urandom);
      if (r < alloc_pct) begin
        send_request(CMD_ALLOC, s);
      end else if (r < alloc_pct + free_pct) begin
        if (tracker.next_slot != 0) s = SLOT_W'($urandom_range(0, tracker.next_slot - 1));
        send_request(CMD_FREE, s);
      end else if (r < alloc_pct + free_pct + rel_pct) begin
        send_request(CMD_RELEASE, s);
      end else if (r[0]) begin
        send_request(CMD_FREE, $urandom_range(0, 1) ? s : tracker.next_slot[SLOT_W-1:0]);
      end else begin
        send_request(CMD_UNKNOWN, s);
      end
    end
  endtask

  initial begin
    cycles            = 0;
    src_idle_pct      = 10;
    sink_stall_pct    = 10;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.cmd        <= CMD_ALLOC;
    req_if.slot_index <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bump allocation, free-list tail, unissued frees, double free
    send_request(CMD_ALLOC, 10'h3FF);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd1);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd3);
    send_request(CMD_FREE, 10'h3FF);
    send_request(CMD_FREE, 10'd0);
    send_request(CMD_FREE, 10'd2);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd0);
    send_request(CMD_FREE, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_UNKNOWN, 10'h3FF);
    send_request(CMD_RELEASE, 10'h2AA);
    send_request(CMD_ALLOC, 10'd0);

    // Directed: oversized block reports out of memory, then zero stride and block size
    configure(13'h1FFF, 11'h7FF);
    send_request(CMD_RELEASE, 10'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_FREE, 10'd5);
    configure(13'd0, 11'd0);
    send_request(CMD_ALLOC, 10'd0);
    send_request(CMD_ALLOC, 10'd0);

    // Random phases over several register settings
    configure(13'd1, 11'd1);
    run_phase(60, 55, 30, 3);
    configure(13'h1FFF, 11'd1024);
    run_phase(50, 50, 35, 3);
    sink_stall_pct = 0;
    configure(13'd0, 11'd0);
    run_phase(60, 50, 35, 5);
    sink_stall_pct = 15;
    src_idle_pct   = 0;
    configure(13'($urandom_range(0, 8191)), 11'($urandom_range(1025, 2047)));
    run_phase(25, 50, 30, 5);
    src_idle_pct = 8;
    configure(13'($urandom_range(0, 8191)), 11'($urandom_range(1, 64)));
    run_phase(60, 55, 30, 3);
    // Fill past one large block so the next block no longer fits
    configure(13'($urandom_range(4096, 8191)), 11'($urandom_range(513, 530)));
    run_phase(560, 97, 2, 0);
    // Last stretch runs back to back on both sides
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    configure(13'($urandom), 11'($urandom_range(1, 200)));
    run_phase(50, 55, 30, 3);

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
